>>> hdl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types, token kind codes, keyword table and byte class helpers for
// the source code tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int POSITION_WIDTH_DEF  = 24;
  localparam int KEYWORD_MAX_LEN_DEF = 8;
  localparam int FIELD_W             = 24;
  localparam int NUM_KW              = 10;
  localparam int MAX_RES             = 3;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       is_end;
  } in_t;

  typedef struct packed {
    logic [5:0]         token_kind;
    logic [FIELD_W-1:0] start_offset;
    logic [FIELD_W-1:0] token_length;
    logic [FIELD_W-1:0] line_number;
    logic [FIELD_W-1:0] column_number;
    logic [1:0]         error_code;
    logic               last_of_run;
  } out_t;

  typedef struct packed {
    logic [1:0]               n;
    out_t [MAX_RES-1:0]       r;
  } res_bundle_t;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_STR, M_CHR, M_SLASH,
    M_LINE, M_BLOCK, M_BSTAR, M_OP, M_GT2, M_DOT2
  } mode_t;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_STR  = 2'd1;
  localparam logic [1:0] ERR_CHR  = 2'd2;
  localparam logic [1:0] ERR_BYTE = 2'd3;

  localparam logic [5:0] K_END      = 6'd0;
  localparam logic [5:0] K_IDENT    = 6'd1;
  localparam logic [5:0] K_KW0      = 6'd2;
  localparam logic [5:0] K_INT      = 6'd12;
  localparam logic [5:0] K_FLOAT    = 6'd13;
  localparam logic [5:0] K_STRING   = 6'd14;
  localparam logic [5:0] K_CHAR     = 6'd15;
  localparam logic [5:0] K_LPAREN   = 6'd16;
  localparam logic [5:0] K_RPAREN   = 6'd17;
  localparam logic [5:0] K_LBRACK   = 6'd18;
  localparam logic [5:0] K_RBRACK   = 6'd19;
  localparam logic [5:0] K_LBRACE   = 6'd20;
  localparam logic [5:0] K_RBRACE   = 6'd21;
  localparam logic [5:0] K_SEMI     = 6'd22;
  localparam logic [5:0] K_COMMA    = 6'd23;
  localparam logic [5:0] K_SCOPE    = 6'd24;
  localparam logic [5:0] K_AND      = 6'd25;
  localparam logic [5:0] K_LAND     = 6'd26;
  localparam logic [5:0] K_OR       = 6'd27;
  localparam logic [5:0] K_LOR      = 6'd28;
  localparam logic [5:0] K_XOR      = 6'd29;
  localparam logic [5:0] K_EQEQ     = 6'd30;
  localparam logic [5:0] K_ASSIGN   = 6'd31;
  localparam logic [5:0] K_PLUSEQ   = 6'd32;
  localparam logic [5:0] K_INC      = 6'd33;
  localparam logic [5:0] K_PLUS     = 6'd34;
  localparam logic [5:0] K_MINUSEQ  = 6'd35;
  localparam logic [5:0] K_DEC      = 6'd36;
  localparam logic [5:0] K_MINUS    = 6'd37;
  localparam logic [5:0] K_MULEQ    = 6'd38;
  localparam logic [5:0] K_POW      = 6'd39;
  localparam logic [5:0] K_MUL      = 6'd40;
  localparam logic [5:0] K_DIVEQ    = 6'd41;
  localparam logic [5:0] K_DIV      = 6'd42;
  localparam logic [5:0] K_MODEQ    = 6'd43;
  localparam logic [5:0] K_MOD      = 6'd44;
  localparam logic [5:0] K_SRSH3    = 6'd45;
  localparam logic [5:0] K_SRSH     = 6'd46;
  localparam logic [5:0] K_GE       = 6'd47;
  localparam logic [5:0] K_GT       = 6'd48;
  localparam logic [5:0] K_SHL      = 6'd49;
  localparam logic [5:0] K_LE       = 6'd50;
  localparam logic [5:0] K_LT       = 6'd51;
  localparam logic [5:0] K_NE       = 6'd52;
  localparam logic [5:0] K_NOT      = 6'd53;
  localparam logic [5:0] K_BNOT     = 6'd54;
  localparam logic [5:0] K_ELLIPSIS = 6'd55;
  localparam logic [5:0] K_PERIOD   = 6'd56;
  localparam logic [5:0] K_ERROR    = 6'd57;

  // operator lookup result
  typedef struct packed {
    logic       hit;
    logic       pend_gt;
    logic       pend_dot;
    logic [5:0] kind;
  } op_t;

  localparam logic [63:0] KW_VAL [NUM_KW] = '{
    64'h6966, 64'h7768696c65, 64'h666f72, 64'h696e636c756465,
    64'h636f6e74696e7565, 64'h70726f6772616d, 64'h72657475726e,
    64'h656c7365, 64'h737472756374, 64'h627265616b};
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd2, 4'd5, 4'd3, 4'd7, 4'd8, 4'd7, 4'd6, 4'd4, 4'd6, 4'd5};

  function automatic logic is_alpha(input logic [7:0] b);
    logic [7:0] l;
    l = b | 8'h20;
    return (l >= "a") && (l <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_name_head(input logic [7:0] b);
    return is_alpha(b) || (b == "_");
  endfunction

  function automatic logic is_name_char(input logic [7:0] b);
    return is_name_head(b) || is_digit(b);
  endfunction

  function automatic op_t op_single(input logic [7:0] c);
    op_t o;
    o = '0;
    o.hit = 1'b1;
    case (c)
      ":": o.kind = K_ERROR;
      "&": o.kind = K_AND;
      "|": o.kind = K_OR;
      "^": o.kind = K_XOR;
      "=": o.kind = K_ASSIGN;
      "+": o.kind = K_PLUS;
      "-": o.kind = K_MINUS;
      "*": o.kind = K_MUL;
      "%": o.kind = K_MOD;
      ">": o.kind = K_GT;
      "<": o.kind = K_LT;
      "!": o.kind = K_NOT;
      ".": o.kind = K_PERIOD;
      default: o.hit = 1'b0;
    endcase
    return o;
  endfunction

  function automatic op_t op_pair(input logic [7:0] c, input logic [7:0] b);
    op_t o;
    o = '0;
    case (c)
      ":": if (b == ":") o = '{1'b1, 1'b0, 1'b0, K_SCOPE};
      "&": begin
        if (b == "=") o = '{1'b1, 1'b0, 1'b0, K_AND};
        else if (b == "&") o = '{1'b1, 1'b0, 1'b0, K_LAND};
      end
      "|": begin
        if (b == "=") o = '{1'b1, 1'b0, 1'b0, K_OR};
        else if (b == "|") o = '{1'b1, 1'b0, 1'b0, K_LOR};
      end
      "^": if (b == "=") o = '{1'b1, 1'b0, 1'b0, K_XOR};
      "=": if (b == "=") o = '{1'b1, 1'b0, 1'b0, K_EQEQ};
      "+": begin
        if (b == "=") o = '{1'b1, 1'b0, 1'b0, K_PLUSEQ};
        else if (b == "+") o = '{1'b1, 1'b0, 1'b0, K_INC};
      end
      "-": begin
        if (b == "=") o = '{1'b1, 1'b0, 1'b0, K_MINUSEQ};
        else if (b == "-") o = '{1'b1, 1'b0, 1'b0, K_DEC};
      end
      "*": begin
        if (b == "=") o = '{1'b1, 1'b0, 1'b0, K_MULEQ};
        else if (b == "*") o = '{1'b1, 1'b0, 1'b0, K_POW};
      end
      "%": if (b == "=") o = '{1'b1, 1'b0, 1'b0, K_MODEQ};
      ">": begin
        if (b == ">") o = '{1'b1, 1'b1, 1'b0, K_SRSH};
        else if (b == "=") o = '{1'b1, 1'b0, 1'b0, K_GE};
      end
      "<": begin
        if (b == "<") o = '{1'b1, 1'b0, 1'b0, K_SHL};
        else if (b == "=") o = '{1'b1, 1'b0, 1'b0, K_LE};
      end
      "!": if (b == "=") o = '{1'b1, 1'b0, 1'b0, K_NE};
      ".": if (b == ".") o = '{1'b1, 1'b0, 1'b1, K_PERIOD};
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

>>> hdl/sct_lex.sv
// ----------------------------------------------------------------------------
// sct_lex
// Scanner state and the per-byte next-state logic. Produces up to three
// tokens for one accepted item.
// ----------------------------------------------------------------------------
module sct_lex #(
  parameter int POSITION_WIDTH  = sct_pkg::POSITION_WIDTH_DEF,
  parameter int KEYWORD_MAX_LEN = sct_pkg::KEYWORD_MAX_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  sct_pkg::in_t         item,
  output sct_pkg::res_bundle_t res
);
  import sct_pkg::*;

  localparam int W = POSITION_WIDTH;
  typedef logic [W-1:0] pos_t;

  mode_t       mode_r, mode_nxt;
  logic [63:0] held_r, held_nxt;
  pos_t        ts_r, ts_nxt, tc_r, tc_nxt, off_r, off_nxt;
  pos_t        ln_r, ln_nxt, co_r, co_nxt, doff_r, doff_nxt, dcol_r, dcol_nxt;

  function automatic pos_t sat_inc(input pos_t x);
    return (x == '1) ? x : x + pos_t'(1);
  endfunction

  function automatic out_t mk(input logic [5:0] k, input pos_t s, input pos_t l,
                              input pos_t li, input pos_t c, input logic [1:0] e);
    out_t o;
    o.token_kind    = k;
    o.start_offset  = FIELD_W'(s);
    o.token_length  = FIELD_W'(l);
    o.line_number   = FIELD_W'(li);
    o.column_number = FIELD_W'(c);
    o.error_code    = e;
    o.last_of_run   = 1'b0;
    return o;
  endfunction

  function automatic logic [5:0] ident_kind(input logic [63:0] h, input pos_t tc);
    logic [5:0] k;
    k = K_IDENT;
    if (tc <= pos_t'(KEYWORD_MAX_LEN)) begin
      for (int i = 0; i < NUM_KW; i++) begin
        if ((tc == pos_t'(KW_LEN[i])) && (h == KW_VAL[i])) k = K_KW0 + 6'(i);
      end
    end
    return k;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic       again;
    logic       cons;
    logic [5:0] k;
    op_t        o;
    pos_t       off_c, ln_c, co_c;
    b        = item.source_byte;
    mode_nxt = mode_r;
    held_nxt = held_r;
    ts_nxt   = ts_r;
    tc_nxt   = tc_r;
    off_nxt  = off_r;
    ln_nxt   = ln_r;
    co_nxt   = co_r;
    doff_nxt = doff_r;
    dcol_nxt = dcol_r;
    res      = '0;
    again    = 1'b1;
    cons     = 1'b0;
    k        = K_ERROR;
    o        = '0;
    // position after the byte is consumed; at most one consume per item
    off_c = sat_inc(off_r);
    if (b == 8'h0a) begin
      ln_c = sat_inc(ln_r);
      co_c = pos_t'(1);
    end else begin
      ln_c = ln_r;
      co_c = sat_inc(co_r);
    end
    if (item.is_end) begin
      case (mode_r)
        M_IDENT: begin
          res.r[res.n] = mk(ident_kind(held_r, tc_r), ts_r, tc_r, ln_r, co_r, ERR_NONE);
          res.n = res.n + 2'd1;
        end
        M_INT, M_FRAC, M_SLASH, M_GT2, M_DOT2: begin
          case (mode_r)
            M_INT:   k = K_INT;
            M_FRAC:  k = K_FLOAT;
            M_SLASH: k = K_DIV;
            M_GT2:   k = K_SRSH;
            default: k = K_PERIOD;
          endcase
          res.r[res.n] = mk(k, ts_r, tc_r, ln_r, co_r, ERR_NONE);
          res.n = res.n + 2'd1;
        end
        M_DOT: begin
          res.r[res.n] = mk(K_INT, ts_r, tc_r - pos_t'(1), ln_r, dcol_r, ERR_NONE);
          res.n = res.n + 2'd1;
          res.r[res.n] = mk(K_PERIOD, doff_r, pos_t'(1), ln_r, co_r, ERR_NONE);
          res.n = res.n + 2'd1;
        end
        M_STR, M_CHR: begin
          res.r[res.n] = mk(K_ERROR, ts_r, tc_r, ln_r, co_r,
                            (mode_r == M_STR) ? ERR_STR : ERR_CHR);
          res.n = res.n + 2'd1;
        end
        M_OP: begin
          o = op_single(held_r[7:0]);
          k = o.hit ? o.kind : K_ERROR;
          res.r[res.n] = mk(k, ts_r, tc_r, ln_r, co_r,
                            (k == K_ERROR) ? ERR_BYTE : ERR_NONE);
          res.n = res.n + 2'd1;
        end
        default: ;
      endcase
      res.r[res.n] = mk(K_END, off_r, '0, ln_r, co_r, ERR_NONE);
      res.n    = res.n + 2'd1;
      mode_nxt = M_IDLE;
      held_nxt = '0;
      ts_nxt   = '0;
      tc_nxt   = '0;
      off_nxt  = '0;
      ln_nxt   = pos_t'(1);
      co_nxt   = pos_t'(1);
      doff_nxt = '0;
      dcol_nxt = '0;
    end else begin
      for (int it = 0; it < 3; it++) begin
        if (again) begin
          again = 1'b0;
          case (mode_nxt)
            M_IDENT: begin
              if (is_name_char(b)) begin
                cons     = 1'b1;
                held_nxt = {held_nxt[55:0], b};
                tc_nxt   = sat_inc(tc_nxt);
              end else begin
                res.r[res.n] = mk(ident_kind(held_nxt, tc_nxt), ts_nxt, tc_nxt, ln_nxt,
                                  co_nxt, ERR_NONE);
                res.n    = res.n + 2'd1;
                mode_nxt = M_IDLE;
                again    = 1'b1;
              end
            end
            M_INT: begin
              if (is_digit(b)) begin
                cons   = 1'b1;
                tc_nxt = sat_inc(tc_nxt);
              end else if (b == ".") begin
                doff_nxt = off_nxt;
                dcol_nxt = co_nxt;
                cons     = 1'b1;
                tc_nxt   = sat_inc(tc_nxt);
                mode_nxt = M_DOT;
              end else begin
                res.r[res.n] = mk(K_INT, ts_nxt, tc_nxt, ln_nxt, co_nxt, ERR_NONE);
                res.n    = res.n + 2'd1;
                mode_nxt = M_IDLE;
                again    = 1'b1;
              end
            end
            M_DOT: begin
              if (is_digit(b)) begin
                cons     = 1'b1;
                tc_nxt   = sat_inc(tc_nxt);
                mode_nxt = M_FRAC;
              end else begin
                res.r[res.n] = mk(K_INT, ts_nxt, tc_nxt - pos_t'(1), ln_nxt, dcol_nxt,
                                  ERR_NONE);
                res.n    = res.n + 2'd1;
                mode_nxt = M_OP;
                held_nxt = 64'(8'h2e);
                ts_nxt   = doff_nxt;
                tc_nxt   = pos_t'(1);
                again    = 1'b1;
              end
            end
            M_FRAC: begin
              if (is_digit(b)) begin
                cons   = 1'b1;
                tc_nxt = sat_inc(tc_nxt);
              end else begin
                res.r[res.n] = mk(K_FLOAT, ts_nxt, tc_nxt, ln_nxt, co_nxt, ERR_NONE);
                res.n    = res.n + 2'd1;
                mode_nxt = M_IDLE;
                again    = 1'b1;
              end
            end
            M_STR, M_CHR: begin
              cons   = 1'b1;
              tc_nxt = sat_inc(tc_nxt);
              if (b == ((mode_nxt == M_STR) ? 8'h22 : 8'h27)) begin
                res.r[res.n] = mk((mode_nxt == M_STR) ? K_STRING : K_CHAR, ts_nxt, tc_nxt,
                                  ln_c, co_c, ERR_NONE);
                res.n    = res.n + 2'd1;
                mode_nxt = M_IDLE;
              end
            end
            M_SLASH: begin
              if (b == "/") begin
                cons     = 1'b1;
                mode_nxt = M_LINE;
              end else if (b == "*") begin
                cons     = 1'b1;
                mode_nxt = M_BLOCK;
              end else if (b == "=") begin
                cons     = 1'b1;
                tc_nxt   = pos_t'(2);
                res.r[res.n] = mk(K_DIVEQ, ts_nxt, pos_t'(2), ln_c, co_c, ERR_NONE);
                res.n    = res.n + 2'd1;
                mode_nxt = M_IDLE;
              end else begin
                res.r[res.n] = mk(K_DIV, ts_nxt, tc_nxt, ln_nxt, co_nxt, ERR_NONE);
                res.n    = res.n + 2'd1;
                mode_nxt = M_IDLE;
                again    = 1'b1;
              end
            end
            M_LINE: begin
              cons = 1'b1;
              if (b == 8'h0a) mode_nxt = M_IDLE;
            end
            M_BLOCK: begin
              cons = 1'b1;
              if (b == "*") mode_nxt = M_BSTAR;
            end
            M_BSTAR: begin
              cons = 1'b1;
              if (b == "/") mode_nxt = M_IDLE;
              else if (b != "*") mode_nxt = M_BLOCK;
            end
            M_OP: begin
              o = op_pair(held_nxt[7:0], b);
              if (o.hit && (o.pend_gt || o.pend_dot)) begin
                cons     = 1'b1;
                tc_nxt   = pos_t'(2);
                mode_nxt = o.pend_gt ? M_GT2 : M_DOT2;
              end else if (o.hit) begin
                cons     = 1'b1;
                tc_nxt   = pos_t'(2);
                res.r[res.n] = mk(o.kind, ts_nxt, pos_t'(2), ln_c, co_c, ERR_NONE);
                res.n    = res.n + 2'd1;
                mode_nxt = M_IDLE;
              end else begin
                o = op_single(held_nxt[7:0]);
                k = o.hit ? o.kind : K_ERROR;
                res.r[res.n] = mk(k, ts_nxt, tc_nxt, ln_nxt, co_nxt,
                                  (k == K_ERROR) ? ERR_BYTE : ERR_NONE);
                res.n    = res.n + 2'd1;
                mode_nxt = M_IDLE;
                again    = 1'b1;
              end
            end
            M_GT2, M_DOT2: begin
              if (b == ((mode_nxt == M_GT2) ? 8'h3e : 8'h2e)) begin
                cons   = 1'b1;
                tc_nxt = pos_t'(3);
                res.r[res.n] = mk((mode_nxt == M_GT2) ? K_SRSH3 : K_ELLIPSIS, ts_nxt,
                                  pos_t'(3), ln_c, co_c, ERR_NONE);
                res.n    = res.n + 2'd1;
                mode_nxt = M_IDLE;
              end else begin
                res.r[res.n] = mk((mode_nxt == M_GT2) ? K_SRSH : K_PERIOD, ts_nxt, tc_nxt,
                                  ln_nxt, co_nxt, ERR_NONE);
                res.n    = res.n + 2'd1;
                mode_nxt = M_IDLE;
                again    = 1'b1;
              end
            end
            default: begin
              mode_nxt = M_IDLE;
              ts_nxt   = off_nxt;
              tc_nxt   = pos_t'(1);
              cons     = 1'b1;
              if (!(b inside {8'h20, 8'h09, 8'h0d, 8'h0a})) begin
                if (b == "/") begin
                  mode_nxt = M_SLASH;
                end else if (is_name_head(b)) begin
                  mode_nxt = M_IDENT;
                  held_nxt = 64'(b);
                end else if (is_digit(b)) begin
                  mode_nxt = M_INT;
                end else if (b == 8'h22) begin
                  mode_nxt = M_STR;
                end else if (b == 8'h27) begin
                  mode_nxt = M_CHR;
                end else begin
                  case (b)
                    "(":     k = K_LPAREN;
                    ")":     k = K_RPAREN;
                    "[":     k = K_LBRACK;
                    "]":     k = K_RBRACK;
                    "{":     k = K_LBRACE;
                    "}":     k = K_RBRACE;
                    ";":     k = K_SEMI;
                    ",":     k = K_COMMA;
                    "~":     k = K_BNOT;
                    default: k = K_ERROR;
                  endcase
                  o = op_single(b);
                  if ((k == K_ERROR) && o.hit) begin
                    mode_nxt = M_OP;
                    held_nxt = 64'(b);
                  end else begin
                    res.r[res.n] = mk(k, off_nxt, pos_t'(1), ln_c, co_c,
                                      (k == K_ERROR) ? ERR_BYTE : ERR_NONE);
                    res.n = res.n + 2'd1;
                  end
                end
              end
            end
          endcase
        end
      end
      if (cons) begin
        off_nxt = off_c;
        ln_nxt  = ln_c;
        co_nxt  = co_c;
      end
    end
    if (res.n != 2'd0) res.r[res.n - 2'd1].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      held_r <= '0;
      ts_r   <= '0;
      tc_r   <= '0;
      off_r  <= '0;
      ln_r   <= pos_t'(1);
      co_r   <= pos_t'(1);
      doff_r <= '0;
      dcol_r <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      ts_r   <= ts_nxt;
      tc_r   <= tc_nxt;
      off_r  <= off_nxt;
      ln_r   <= ln_nxt;
      co_r   <= co_nxt;
      doff_r <= doff_nxt;
      dcol_r <= dcol_nxt;
    end
  end

endmodule

>>> hdl/sct_obuf.sv
// ----------------------------------------------------------------------------
// sct_obuf
// Result register bank: holds the tokens of one item and hands them out one
// per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module sct_obuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sct_pkg::res_bundle_t res,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sct_pkg::out_t        out_data
);
  import sct_pkg::*;

  out_t [MAX_RES-1:0] buf_r;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [1:0]         rd_r, rd_nxt;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf_r[rd_r];
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    if (load) begin
      cnt_nxt = res.n;
      rd_nxt  = '0;
    end else if (out_valid && out_ready) begin
      cnt_nxt = cnt_r - 2'd1;
      rd_nxt  = rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) buf_r <= res.r;
  end

endmodule

>>> hdl/source_code_tokenizer.sv
// ----------------------------------------------------------------------------
// source_code_tokenizer
// Streaming lexer: one source byte per item in, tokens out.
// Output: an item's tokens are registered; the first appears in the next cycle.
// Throughput: one item per cycle while each item yields at most one token and
// out_ready is high; an item with more tokens holds off new items until its last is taken.
// Reset: synchronous, active low; line and column restart at one.
// ----------------------------------------------------------------------------
module source_code_tokenizer #(
  parameter int POSITION_WIDTH  = sct_pkg::POSITION_WIDTH_DEF,
  parameter int KEYWORD_MAX_LEN = sct_pkg::KEYWORD_MAX_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sct_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sct_pkg::out_t out_data
);
  import sct_pkg::*;

  res_bundle_t res;
  logic        take;

  assign take = in_valid && in_ready;

  sct_lex #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
  ) u_lex (
    .clk  (clk),
    .rst_n(rst_n),
    .take (take),
    .item (in_data),
    .res  (res)
  );

  sct_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take),
    .res      (res),
    .can_load (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Tokenizer testbench
// Drives source bytes and end marks into the source code tokenizer, predicts
// every token with a behavioral lexer of its own, and compares the tokens
// field by field against the predicted ones in order.
// ----------------------------------------------------------------------------
class token_scoreboard;
  typedef enum int {
    S_IDLE, S_IDENT, S_INT, S_DOT, S_FRAC, S_STR, S_CHR, S_SLASH,
    S_LINE, S_BLOCK, S_BSTAR, S_OP, S_GT2, S_DOT2
  } lex_state_e;

  localparam logic [23:0] POS_MAX = 24'hFFFFFF;

  sct_pkg::out_t expected_tokens[$];
  int errors;
  int tokens_seen;
  lex_state_e st;
  logic [63:0] held;
  logic [23:0] tok_start, tok_len, offset, line, col, dot_off, dot_col;
  sct_pkg::out_t step_tokens[$];

  function new();
    errors = 0;
    tokens_seen = 0;
    clear();
  endfunction

  function void clear();
    st = S_IDLE;
    held = '0;
    tok_start = '0;
    tok_len = '0;
    offset = '0;
    line = 24'd1;
    col = 24'd1;
    dot_off = '0;
    dot_col = '0;
  endfunction

  function logic [23:0] inc(logic [23:0] x);
    return (x == POS_MAX) ? x : x + 24'd1;
  endfunction

  function bit alpha_b(logic [7:0] b);
    logic [7:0] l;
    l = b | 8'h20;
    return l >= "a" && l <= "z";
  endfunction

  function bit digit_b(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function bit name_b(logic [7:0] b);
    return alpha_b(b) || b == "_" || digit_b(b);
  endfunction

  function void advance(logic [7:0] b);
    offset = inc(offset);
    if (b == 8'h0a) begin
      line = inc(line);
      col = 24'd1;
    end else begin
      col = inc(col);
    end
  endfunction

  function void add(logic [5:0] k, logic [23:0] s, logic [23:0] n, logic [23:0] c,
                    logic [1:0] e);
    sct_pkg::out_t t;
    t.token_kind = k;
    t.start_offset = s;
    t.token_length = n;
    t.line_number = line;
    t.column_number = c;
    t.error_code = e;
    t.last_of_run = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function void add_pending(logic [5:0] k);
    add(k, tok_start, tok_len, col, (k == sct_pkg::K_ERROR) ? sct_pkg::ERR_BYTE
                                                          : sct_pkg::ERR_NONE);
  endfunction

  function logic [5:0] name_kind();
    string kw[10];
    logic [63:0] v;
    kw = '{"if", "while", "for", "include", "continue", "program", "return",
           "else", "struct", "break"};
    if (tok_len > 24'd8) return sct_pkg::K_IDENT;
    foreach (kw[i]) begin
      if (kw[i].len() != tok_len) continue;
      v = '0;
      for (int j = 0; j < kw[i].len(); j++) v = {v[55:0], kw[i][j]};
      if (v == held) return sct_pkg::K_KW0 + 6'(i);
    end
    return sct_pkg::K_IDENT;
  endfunction

  function int lone_op(logic [7:0] c);
    case (c)
      ":": return int'(sct_pkg::K_ERROR);
      "&": return int'(sct_pkg::K_AND);
      "|": return int'(sct_pkg::K_OR);
      "^": return int'(sct_pkg::K_XOR);
      "=": return int'(sct_pkg::K_ASSIGN);
      "+": return int'(sct_pkg::K_PLUS);
      "-": return int'(sct_pkg::K_MINUS);
      "*": return int'(sct_pkg::K_MUL);
      "%": return int'(sct_pkg::K_MOD);
      ">": return int'(sct_pkg::K_GT);
      "<": return int'(sct_pkg::K_LT);
      "!": return int'(sct_pkg::K_NOT);
      ".": return int'(sct_pkg::K_PERIOD);
      default: return -1;
    endcase
  endfunction

  // -2: '>>' pending, -3: '..' pending, -1: no pair
  function int pair_op(logic [7:0] c, logic [7:0] b);
    case (c)
      ":": if (b == ":") return int'(sct_pkg::K_SCOPE);
      "&": if (b == "=") return int'(sct_pkg::K_AND);
           else if (b == "&") return int'(sct_pkg::K_LAND);
      "|": if (b == "=") return int'(sct_pkg::K_OR);
           else if (b == "|") return int'(sct_pkg::K_LOR);
      "^": if (b == "=") return int'(sct_pkg::K_XOR);
      "=": if (b == "=") return int'(sct_pkg::K_EQEQ);
      "+": if (b == "=") return int'(sct_pkg::K_PLUSEQ);
           else if (b == "+") return int'(sct_pkg::K_INC);
      "-": if (b == "=") return int'(sct_pkg::K_MINUSEQ);
           else if (b == "-") return int'(sct_pkg::K_DEC);
      "*": if (b == "=") return int'(sct_pkg::K_MULEQ);
           else if (b == "*") return int'(sct_pkg::K_POW);
      "%": if (b == "=") return int'(sct_pkg::K_MODEQ);
      ">": if (b == ">") return -2; else if (b == "=") return int'(sct_pkg::K_GE);
      "<": if (b == "<") return int'(sct_pkg::K_SHL);
           else if (b == "=") return int'(sct_pkg::K_LE);
      "!": if (b == "=") return int'(sct_pkg::K_NE);
      ".": if (b == ".") return -3;
      default: return -1;
    endcase
    return -1;
  endfunction

  function void start_byte(logic [7:0] b);
    logic [5:0] k;
    logic [23:0] at;
    at = offset;
    tok_start = at;
    tok_len = 24'd1;
    advance(b);
    if (b == " " || b == 8'h09 || b == 8'h0d || b == 8'h0a) return;
    if (b == "/") begin st = S_SLASH; return; end
    if (alpha_b(b) || b == "_") begin st = S_IDENT; held = 64'(b); return; end
    if (digit_b(b)) begin st = S_INT; return; end
    if (b == "\"") begin st = S_STR; return; end
    if (b == "'") begin st = S_CHR; return; end
    case (b)
      "(": k = sct_pkg::K_LPAREN;
      ")": k = sct_pkg::K_RPAREN;
      "[": k = sct_pkg::K_LBRACK;
      "]": k = sct_pkg::K_RBRACK;
      "{": k = sct_pkg::K_LBRACE;
      "}": k = sct_pkg::K_RBRACE;
      ";": k = sct_pkg::K_SEMI;
      ",": k = sct_pkg::K_COMMA;
      "~": k = sct_pkg::K_BNOT;
      default: begin
        if (lone_op(b) >= 0) begin st = S_OP; held = 64'(b); return; end
        k = sct_pkg::K_ERROR;
      end
    endcase
    add(k, at, 24'd1, col, (k == sct_pkg::K_ERROR) ? sct_pkg::ERR_BYTE : sct_pkg::ERR_NONE);
  endfunction

  function void flush_pending();
    int s;
    case (st)
      S_IDENT: add_pending(name_kind());
      S_INT: add_pending(sct_pkg::K_INT);
      S_DOT: begin
        add(sct_pkg::K_INT, tok_start, tok_len - 24'd1, dot_col, sct_pkg::ERR_NONE);
        add(sct_pkg::K_PERIOD, dot_off, 24'd1, col, sct_pkg::ERR_NONE);
      end
      S_FRAC: add_pending(sct_pkg::K_FLOAT);
      S_STR: add(sct_pkg::K_ERROR, tok_start, tok_len, col, sct_pkg::ERR_STR);
      S_CHR: add(sct_pkg::K_ERROR, tok_start, tok_len, col, sct_pkg::ERR_CHR);
      S_SLASH: add_pending(sct_pkg::K_DIV);
      S_OP: begin
        s = lone_op(held[7:0]);
        add_pending(s < 0 ? sct_pkg::K_ERROR : s[5:0]);
      end
      S_GT2: add_pending(sct_pkg::K_SRSH);
      S_DOT2: add_pending(sct_pkg::K_PERIOD);
      default: ;
    endcase
  endfunction

  // Predicts the tokens caused by one accepted item and queues them.
  function int note_item(sct_pkg::in_t it);
    logic [7:0] b;
    bit again;
    int k;
    b = it.source_byte;
    step_tokens.delete();
    if (it.is_end) begin
      flush_pending();
      add(sct_pkg::K_END, offset, 24'd0, col, sct_pkg::ERR_NONE);
      clear();
    end else begin
      again = 1;
      while (again) begin
        again = 0;
        case (st)
          S_IDENT:
            if (name_b(b)) begin
              advance(b); held = {held[55:0], b}; tok_len = inc(tok_len);
            end else begin
              add_pending(name_kind()); st = S_IDLE; again = 1;
            end
          S_INT:
            if (digit_b(b)) begin
              advance(b); tok_len = inc(tok_len);
            end else if (b == ".") begin
              dot_off = offset; dot_col = col;
              advance(b); tok_len = inc(tok_len); st = S_DOT;
            end else begin
              add_pending(sct_pkg::K_INT); st = S_IDLE; again = 1;
            end
          S_DOT:
            if (digit_b(b)) begin
              advance(b); tok_len = inc(tok_len); st = S_FRAC;
            end else begin
              add(sct_pkg::K_INT, tok_start, tok_len - 24'd1, dot_col, sct_pkg::ERR_NONE);
              st = S_OP; held = 64'(8'h2e); tok_start = dot_off; tok_len = 24'd1;
              again = 1;
            end
          S_FRAC:
            if (digit_b(b)) begin
              advance(b); tok_len = inc(tok_len);
            end else begin
              add_pending(sct_pkg::K_FLOAT); st = S_IDLE; again = 1;
            end
          S_STR, S_CHR: begin
            advance(b); tok_len = inc(tok_len);
            if (b == ((st == S_STR) ? 8'h22 : 8'h27)) begin
              add_pending((st == S_STR) ? sct_pkg::K_STRING : sct_pkg::K_CHAR);
              st = S_IDLE;
            end
          end
          S_SLASH:
            if (b == "/") begin
              advance(b); st = S_LINE;
            end else if (b == "*") begin
              advance(b); st = S_BLOCK;
            end else if (b == "=") begin
              advance(b); tok_len = 24'd2; add_pending(sct_pkg::K_DIVEQ); st = S_IDLE;
            end else begin
              add_pending(sct_pkg::K_DIV); st = S_IDLE; again = 1;
            end
          S_LINE: begin
            advance(b);
            if (b == 8'h0a) st = S_IDLE;
          end
          S_BLOCK: begin
            advance(b);
            if (b == "*") st = S_BSTAR;
          end
          S_BSTAR: begin
            advance(b);
            if (b == "/") st = S_IDLE;
            else if (b != "*") st = S_BLOCK;
          end
          S_OP: begin
            k = pair_op(held[7:0], b);
            if (k == -2 || k == -3) begin
              advance(b); tok_len = 24'd2; st = (k == -2) ? S_GT2 : S_DOT2;
            end else if (k >= 0) begin
              advance(b); tok_len = 24'd2; add_pending(k[5:0]); st = S_IDLE;
            end else begin
              k = lone_op(held[7:0]);
              add_pending(k < 0 ? sct_pkg::K_ERROR : k[5:0]);
              st = S_IDLE; again = 1;
            end
          end
          S_GT2, S_DOT2:
            if (b == ((st == S_GT2) ? 8'h3e : 8'h2e)) begin
              advance(b); tok_len = 24'd3;
              add_pending((st == S_GT2) ? sct_pkg::K_SRSH3 : sct_pkg::K_ELLIPSIS);
              st = S_IDLE;
            end else begin
              add_pending((st == S_GT2) ? sct_pkg::K_SRSH : sct_pkg::K_PERIOD);
              st = S_IDLE; again = 1;
            end
          default: begin
            st = S_IDLE;
            start_byte(b);
          end
        endcase
      end
    end
    if (step_tokens.size() > 0) step_tokens[$].last_of_run = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    return step_tokens.size();
  endfunction

  function void check_token(sct_pkg::out_t got);
    sct_pkg::out_t w;
    tokens_seen++;
    if (expected_tokens.size() == 0) begin
      $error("token with none expected: kind %0d", got.token_kind);
      errors++;
      return;
    end
    w = expected_tokens.pop_front();
    if (got.token_kind !== w.token_kind) begin
      $error("token_kind: expected %0d, got %0d", w.token_kind, got.token_kind); errors++;
    end
    if (got.start_offset !== w.start_offset) begin
      $error("start_offset: expected %0d, got %0d", w.start_offset, got.start_offset); errors++;
    end
    if (got.token_length !== w.token_length) begin
      $error("token_length: expected %0d, got %0d", w.token_length, got.token_length); errors++;
    end
    if (got.line_number !== w.line_number) begin
      $error("line_number: expected %0d, got %0d", w.line_number, got.line_number); errors++;
    end
    if (got.column_number !== w.column_number) begin
      $error("column_number: expected %0d, got %0d", w.column_number, got.column_number);
      errors++;
    end
    if (got.error_code !== w.error_code) begin
      $error("error_code: expected %0d, got %0d", w.error_code, got.error_code); errors++;
    end
    if (got.last_of_run !== w.last_of_run) begin
      $error("last_of_run: expected %0d, got %0d", w.last_of_run, got.last_of_run); errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sct_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sct_pkg::out_t out_data;

  token_scoreboard board;
  int send_idle_pct = 20;
  int recv_idle_pct = 46;
  bit hold_off = 0;
  int cycles = 0;
  int items_sent = 0;

  source_code_tokenizer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_token(out_data);
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(input logic [7:0] b, input bit e);
    sct_pkg::in_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.source_byte = b;
    it.is_end = e;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    void'(board.note_item(it));
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic byte unsigned pick_byte();
    string alpha;
    alpha = "aZ_09 \t\r\n/*\"'()[]{};,~:&|^=+-%<>!.";
    case ($urandom_range(9))
      0: return 8'($urandom_range(255));
      1, 2: return 8'("a" + $urandom_range(25));
      3: return 8'("0" + $urandom_range(9));
      default: return alpha[$urandom_range(alpha.len() - 1)];
    endcase
  endfunction

  task automatic random_fragment();
    string words[14];
    words = '{"if ", "while(", "for ", "include ", "continue;", "program ", "return ",
              "else{", "struct ", "break;", "x1 = 3.25;", "a>>>=b", "s=\"hi\";",
              "/* c ** */ y // n\n"};
    case ($urandom_range(3))
      0: send_text(words[$urandom_range(13)]);
      default: send_item(pick_byte(), 1'b0);
    endcase
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: keywords, numbers, dot cases, operators, errors, comments
    send_text("if x_9 1. .. ...a:b");
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h80, 1'b0);
    send_text("/*/ **/ continuex\"s");
    send_item(8'h00, 1'b1);
    send_text("'c");
    send_item(8'hff, 1'b1);
    send_text("/* open");
    send_item(8'h00, 1'b1);

    // pressure: stall the result side while items keep coming
    hold_off = 1;
    fork
      begin
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      send_text("(a,b)[c]{d};~x::y&&z||w^=1==2!=3<=4<<5>=6");
    join

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 20 : 0;
      while (items_sent < 80 * (phase + 1) + 90) begin
        random_fragment();
        if ($urandom_range(29) == 0) send_item(8'($urandom_range(255)), 1'b1);
      end
    end
    send_item(8'h20, 1'b1);
    in_valid <= 1'b0;

    while (board.expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d items (bytes, end marks, keywords, literals, comments, errors)",
             items_sent);
    $display("checked %0d tokens with %0d mismatches", board.tokens_seen, board.errors);
    if (board.errors == 0 && board.expected_tokens.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
